[rtl/core/mbrf_pkg.sv]
// Package for the Modbus RTU request framer: frame constants, byte and
// index types, and the byte-wide CRC-16 update function.
// Depends on nothing; imported by modbus_rtu_request_framer and its testbench.
`default_nettype none

package mbrf_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  idx_t;
  typedef logic [15:0] crc_t;

  localparam crc_t  CRC_INIT      = 16'hFFFF;
  localparam crc_t  CRC_POLY      = 16'hA001;
  localparam idx_t  LAST_INDEX    = 3'd7;
  localparam idx_t  FIRST_CRC_IDX = 3'd6;
  localparam int    PAYLOAD_BITS  = 48;

  function automatic crc_t crc16_update(input crc_t crc, input byte_t octet);
    crc_t acc;
    acc = crc ^ {8'h00, octet};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

[rtl/core/modbus_rtu_request_framer.sv]
// Top level of the Modbus RTU request framer: serializes one request into
// an eight-byte frame with its CRC-16. Depends on mbrf_pkg.
//
//   channel   handshake              payload
//   request   start / busy           device_id, function_code,
//                                    register_address, register_data
//   config    cfg_write_en           cfg_write_data (crc_low_byte_first)
//   frame     strobe (one cycle)     frame_byte, byte_index, last_byte
//
// A request is taken at an edge with start high and busy low. It is loaded
// into the shift register and the active flag, and its eight bytes then pass
// through the output registers back to back. The CRC is updated one byte per
// cycle as bytes 0 to 5 leave. Busy falls while the last byte is being
// loaded, so back-to-back requests run without a gap.
// Reset is synchronous and clears the control state and the config flag.
`default_nettype none

module modbus_rtu_request_framer
  import mbrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  device_id,
  input  wire logic [7:0]  function_code,
  input  wire logic [15:0] register_address,
  input  wire logic [15:0] register_data,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_write_data,
  output logic             strobe,
  output logic [7:0]       frame_byte,
  output logic [2:0]       byte_index,
  output logic             last_byte
);

  logic                    crc_low_byte_first;
  logic                    active, active_next;
  idx_t                    cnt, cnt_next;
  crc_t                    crc, crc_next;
  logic [PAYLOAD_BITS-1:0] shreg, shreg_next;
  logic                    strobe_next;
  byte_t                   frame_byte_next;
  idx_t                    byte_index_next;
  logic                    last_byte_next;
  logic                    accept;

  assign busy   = active && (cnt != LAST_INDEX);
  assign accept = start && !busy;

  always_comb begin
    active_next     = active;
    cnt_next        = cnt;
    crc_next        = crc;
    shreg_next      = shreg;
    strobe_next     = 1'b0;
    frame_byte_next = shreg[PAYLOAD_BITS-1 -: 8];
    byte_index_next = cnt;
    last_byte_next  = 1'b0;
    if (active) begin
      strobe_next    = 1'b1;
      last_byte_next = (cnt == LAST_INDEX);
      cnt_next       = cnt + 3'd1;
      if (cnt < FIRST_CRC_IDX) begin
        crc_next   = crc16_update(crc, shreg[PAYLOAD_BITS-1 -: 8]);
        shreg_next = {shreg[PAYLOAD_BITS-9:0], 8'h00};
      end else if (cnt == FIRST_CRC_IDX) begin
        frame_byte_next = crc_low_byte_first ? crc[7:0] : crc[15:8];
      end else begin
        frame_byte_next = crc_low_byte_first ? crc[15:8] : crc[7:0];
        active_next     = 1'b0;
      end
    end
    if (accept) begin
      active_next = 1'b1;
      cnt_next    = '0;
      crc_next    = CRC_INIT;
      shreg_next  = {device_id, function_code, register_address, register_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active             <= 1'b0;
      cnt                <= '0;
      strobe             <= 1'b0;
      crc_low_byte_first <= 1'b0;
    end else begin
      active <= active_next;
      cnt    <= cnt_next;
      strobe <= strobe_next;
      if (cfg_write_en) begin
        crc_low_byte_first <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    crc        <= crc_next;
    shreg      <= shreg_next;
    frame_byte <= frame_byte_next;
    byte_index <= byte_index_next;
    last_byte  <= last_byte_next;
  end

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    strobe && last_byte |-> byte_index == LAST_INDEX)
    else $error("last_byte set on a byte other than the final one");

  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && (byte_index != LAST_INDEX) |=> strobe && (byte_index == $past(byte_index) + 3'd1))
    else $error("frame bytes not emitted on consecutive cycles");

  a_accept_starts_frame: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 strobe && (byte_index == 3'd0))
    else $error("accepted transaction did not start a frame");

  a_busy_emits: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("busy without frame output");

endmodule

`default_nettype wire

[tb/modbus_rtu_request_framer_test.sv]
// Testbench for modbus_rtu_request_framer: drives requests, predicts each
// eight-byte frame with its CRC-16, and checks every strobed byte in order.
// Depends on mbrf_pkg and modbus_rtu_request_framer.
`timescale 1ns / 100ps

module modbus_rtu_request_framer_test;
  import mbrf_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic [7:0]  device_id;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] register_data;
  } request_t;

  typedef struct packed {
    byte_t value;
    idx_t  index;
    logic  last;
  } frame_slot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  device_id = '0;
  logic [7:0]  function_code = '0;
  logic [15:0] register_address = '0;
  logic [15:0] register_data = '0;
  logic        cfg_write_en = 1'b0;
  logic        cfg_write_data = 1'b0;
  logic        strobe;
  logic [7:0]  frame_byte;
  logic [2:0]  byte_index;
  logic        last_byte;

  request_t    pending_requests[$];
  frame_slot_t expected_frame_bytes[$];
  request_t    current_request;
  logic        crc_low_first_model = 1'b0;
  logic        random_gaps = 1'b1;
  int          gap_left = 0;
  int          stall_cycles = 0;
  int          error_count = 0;

  modbus_rtu_request_framer uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .device_id        (device_id),
    .function_code    (function_code),
    .register_address (register_address),
    .register_data    (register_data),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .strobe           (strobe),
    .frame_byte       (frame_byte),
    .byte_index       (byte_index),
    .last_byte        (last_byte)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic crc_t payload_crc(input logic [47:0] payload);
    crc_t acc;
    acc = CRC_INIT;
    for (int k = 5; k >= 0; k--) begin
      acc ^= {8'h00, payload[k*8 +: 8]};
      for (int b = 0; b < 8; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  function automatic void queue_request_frame(input request_t req);
    logic [47:0] payload;
    crc_t        crc;
    byte_t       bytes[8];
    frame_slot_t slot;
    payload = {req.device_id, req.function_code, req.register_address, req.register_data};
    crc = payload_crc(payload);
    for (int k = 0; k < 6; k++) begin
      bytes[k] = payload[(5 - k)*8 +: 8];
    end
    if (crc_low_first_model) begin
      bytes[6] = crc[7:0];
      bytes[7] = crc[15:8];
    end else begin
      bytes[6] = crc[15:8];
      bytes[7] = crc[7:0];
    end
    for (int k = 0; k < 8; k++) begin
      slot.value = bytes[k];
      slot.index = idx_t'(k);
      slot.last  = (k == 7);
      expected_frame_bytes.push_back(slot);
    end
  endfunction

  always @(posedge clk) begin : driver
    logic launch;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      launch = start;
      if (start && !busy) begin
        queue_request_frame(current_request);
        launch = 1'b0;
        gap_left = random_gaps ? $urandom_range(0, 8) : 0;
      end
      if (!launch && pending_requests.size() > 0) begin
        if (gap_left == 0) begin
          current_request = pending_requests.pop_front();
          device_id        <= current_request.device_id;
          function_code    <= current_request.function_code;
          register_address <= current_request.register_address;
          register_data    <= current_request.register_data;
          launch = 1'b1;
        end else begin
          gap_left--;
        end
      end
      start <= launch;
    end
  end

  always @(posedge clk) begin : monitor
    frame_slot_t want;
    if (!rst && strobe) begin
      if (expected_frame_bytes.size() == 0) begin
        $error("frame_byte with no transaction pending: actual %h", frame_byte);
        error_count++;
      end else begin
        want = expected_frame_bytes.pop_front();
        if (frame_byte !== want.value) begin
          $error("frame_byte mismatch: expected %h, actual %h", want.value, frame_byte);
          error_count++;
        end
        if (byte_index !== want.index) begin
          $error("byte_index mismatch: expected %0d, actual %0d", want.index, byte_index);
          error_count++;
        end
        if (last_byte !== want.last) begin
          $error("last_byte mismatch: expected %b, actual %b", want.last, last_byte);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL modbus_rtu_request_framer");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_request(input logic [7:0] dev, input logic [7:0] func,
                             input logic [15:0] addr, input logic [15:0] data);
    request_t req;
    req = '{device_id: dev, function_code: func, register_address: addr,
            register_data: data};
    pending_requests.push_back(req);
  endtask

  task automatic add_directed_requests();
    add_request(8'h00, 8'h00, 16'h0000, 16'h0000);
    add_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    add_request(8'h01, 8'h03, 16'h0000, 16'h000A);
    add_request(8'h01, 8'h06, 16'h0001, 16'h0003);
    add_request(8'hFF, 8'h00, 16'hFFFF, 16'h0000);
    add_request(8'h00, 8'hFF, 16'h0000, 16'hFFFF);
    add_request(8'hAA, 8'h55, 16'hA5A5, 16'h5A5A);
    add_request(8'h55, 8'hAA, 16'h5A5A, 16'hA5A5);
    add_request(8'h80, 8'h01, 16'h8000, 16'h0001);
    add_request(8'h01, 8'h80, 16'h0001, 16'h8000);
  endtask

  task automatic add_random_requests(input int count);
    logic [7:0] typical_codes[4];
    typical_codes = '{8'h03, 8'h04, 8'h06, 8'h10};
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        add_request(8'($urandom_range(1, 247)), typical_codes[$urandom_range(0, 3)],
                    16'($urandom_range(0, 255)), 16'($urandom_range(0, 125)));
      end else begin
        add_request(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic wait_until_idle();
    while (pending_requests.size() != 0 || start || expected_frame_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_crc_order(input logic value);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    crc_low_first_model = value;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= 1'($urandom_range(0, 1));
  endtask

  initial begin
    logic order_plan[6];
    order_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    add_directed_requests();
    wait_until_idle();
    write_crc_order(1'b1);
    add_directed_requests();
    wait_until_idle();

    for (int phase = 0; phase < 6; phase++) begin
      write_crc_order(order_plan[phase]);
      random_gaps = (phase % 2 == 0);
      add_random_requests(PHASE_ITEMS);
      wait_until_idle();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS modbus_rtu_request_framer");
    end else begin
      $display("FAIL modbus_rtu_request_framer");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mbrf_pkg.sv
rtl/core/modbus_rtu_request_framer.sv
tb/modbus_rtu_request_framer_test.sv
